>>> sv/assert_macros.svh
// assertion macros used by the checker file
// expects clk and rst in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("camera core check failed");

// next-cycle implication, quiet while reset is high
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("camera core check failed");

`endif

>>> sv/cebm_pkg.sv
// types, codes and constants of the camera basis and motion core
// no dependencies
`timescale 1ns / 1ps

package cebm_pkg;

  localparam int FULL_TURN    = 23040;
  localparam int QUARTER_TURN = 5760;
  localparam int RECIP_SH     = 38;
  localparam int RECIP_W      = 26;

  localparam logic [3:0] OP_RECOMPUTE  = 4'd0;
  localparam logic [3:0] OP_FWD        = 4'd1;
  localparam logic [3:0] OP_BACK       = 4'd2;
  localparam logic [3:0] OP_UP         = 4'd3;
  localparam logic [3:0] OP_DOWN       = 4'd4;
  localparam logic [3:0] OP_STRAFE_R   = 4'd5;
  localparam logic [3:0] OP_STRAFE_L   = 4'd6;
  localparam logic [3:0] OP_TURN_LEFT  = 4'd7;
  localparam logic [3:0] OP_TURN_RIGHT = 4'd8;
  localparam logic [3:0] OP_TURN_UP    = 4'd9;
  localparam logic [3:0] OP_TURN_DOWN  = 4'd10;

  localparam logic [2:0] CFG_ROLL  = 3'd0;
  localparam logic [2:0] CFG_PITCH = 3'd1;
  localparam logic [2:0] CFG_YAW   = 3'd2;
  localparam logic [2:0] CFG_POS_X = 3'd3;
  localparam logic [2:0] CFG_POS_Y = 3'd4;
  localparam logic [2:0] CFG_POS_Z = 3'd5;

  localparam logic [15:0]        RST_YAW   = 16'd17280;
  localparam logic signed [13:0] RST_PITCH = -14'sd2880;

  typedef enum logic [3:0] {
    A_SY, A_CY, A_SP, A_CP, A_T, A_FX, A_FY, A_FZ, A_K
  } asel_t;

  typedef enum logic [3:0] {
    B_CP, B_CY, B_CR, B_SP, B_SR, B_UX, B_UY, B_UZ, B_V0, B_V1, B_V2
  } bsel_t;

  typedef enum logic [2:0] {
    M_HOLD, M_LOAD, M_NLOAD, M_SUB, M_NSH_SUB, M_NSH_ADD
  } mode_t;

  typedef enum logic [3:0] {
    W_NONE, W_FX, W_FY, W_FZ, W_UX, W_UY, W_UZ, W_T,
    W_RX, W_RY, W_RZ, W_P0, W_P1, W_P2
  } wb_t;

  typedef enum logic [2:0] {
    ANG_SIN_YAW, ANG_COS_YAW, ANG_SIN_PITCH, ANG_COS_PITCH, ANG_SIN_ROLL, ANG_COS_ROLL
  } ang_t;

  typedef struct packed {
    asel_t a_sel;
    bsel_t b_sel;
    mode_t mode;
    wb_t   wb;
    ang_t  sin_ang;
    logic  sin_cap;
    ang_t  cap_sel;
  } ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } stat_t;

  function automatic logic signed [15:0] clamp_unit(input logic signed [47:0] v);
    if (v > 48'sd16384) return 16'sd16384;
    if (v < -48'sd16384) return -16'sd16384;
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    if (v < -50'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

>>> sv/cebm_sine.sv
// pipelined sine: angle reduction, reciprocal index scaling, quarter-wave rom
// depends on cebm_pkg; registered through n_q, x_q and val_q, one angle per cycle
`timescale 1ns / 1ps

module cebm_sine import cebm_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic               clk,
  input  logic signed [16:0] angle,
  output logic signed [15:0] sine
);

  localparam int QS = (DEPTH / 4 > 0) ? DEPTH / 4 : 1;
  localparam int XW = $clog2(QS + 1);
  localparam int NW = $clog2(QUARTER_TURN * QS + QUARTER_TURN / 2 + 1);
  localparam logic [RECIP_W-1:0] MREC =
    RECIP_W'((64'd1 << RECIP_SH) / QUARTER_TURN + 64'd1);

  typedef logic [14:0] tbl_t [QS+1];

  function automatic tbl_t build_table();
    longint unsigned u, u2, h, s;
    tbl_t t;
    for (int i = 0; i <= QS; i++) begin
      u  = longint'(i) * 64'd1686629713 / QS;
      u2 = (u * u) >> 30;
      h  = 64'd1073741824 - u2 / 72;
      h  = 64'd1073741824 - ((u2 * h) >> 30) / 42;
      h  = 64'd1073741824 - ((u2 * h) >> 30) / 20;
      h  = 64'd1073741824 - ((u2 * h) >> 30) / 6;
      s  = (u * h) >> 30;
      s  = (s + 64'd32768) >> 16;
      if (s > 64'd16384) s = 64'd16384;
      t[i] = s[14:0];
    end
    return t;
  endfunction

  localparam tbl_t SIN_TBL = build_table();

  logic signed [16:0]     wrapped;
  logic [14:0]            m;
  logic [12:0]            r;
  logic                   neg0;
  logic [NW-1:0]          n_d, n_q;
  logic [NW+RECIP_W-1:0]  prod;
  logic [XW-1:0]          x_q;
  logic [14:0]            val_q;
  logic                   neg1, neg2, neg3;

  // fold into one turn, then into the first quadrant
  always_comb begin
    if (angle < 17'sd0) begin
      wrapped = angle + 17'sd23040;
    end else if (angle >= 17'sd23040) begin
      wrapped = angle - 17'sd23040;
    end else begin
      wrapped = angle;
    end
    m = wrapped[14:0];
    if (m < 15'd5760) begin
      r = m[12:0]; neg0 = 1'b0;
    end else if (m < 15'd11520) begin
      r = 13'(15'd11520 - m); neg0 = 1'b0;
    end else if (m < 15'd17280) begin
      r = 13'(m - 15'd11520); neg0 = 1'b1;
    end else begin
      r = 13'(15'd23040 - m); neg0 = 1'b1;
    end
    n_d = NW'(r) * NW'(QS) + NW'(QUARTER_TURN / 2);
  end

  // divide by a quarter turn through the reciprocal
  assign prod = NW'(n_q) * (NW + RECIP_W)'(MREC);

  always_ff @(posedge clk) begin
    n_q   <= n_d;
    neg1  <= neg0;
    x_q   <= XW'(prod >> RECIP_SH);
    neg2  <= neg1;
    val_q <= SIN_TBL[x_q];
    neg3  <= neg2;
  end

  assign sine = neg3 ? -$signed({1'b0, val_q}) : $signed({1'b0, val_q});

endmodule

>>> sv/cebm_mac.sv
// shared 32x16 signed multiplier with an accumulator behind it
// depends on cebm_pkg for the accumulate modes
`timescale 1ns / 1ps

module cebm_mac import cebm_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [15:0] b,
  input  mode_t              mode,
  output logic signed [47:0] acc
);

  logic signed [47:0] prod;

  assign prod = 48'(a) * 48'(b);

  always_ff @(posedge clk) begin
    case (mode)
      M_LOAD:    acc <= prod;
      M_NLOAD:   acc <= -prod;
      M_SUB:     acc <= acc - prod;
      M_NSH_SUB: acc <= -(acc <<< 14) - prod;
      M_NSH_ADD: acc <= -(acc <<< 14) + prod;
      default:   acc <= acc;
    endcase
  end

endmodule

>>> sv/cebm_seq.sv
// step sequencer: move products, sine issue and capture, basis and right products
// depends on cebm_pkg for the control struct and codes
`timescale 1ns / 1ps

module cebm_seq import cebm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  go_move,
  output ctrl_t ctrl,
  output stat_t stat
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MOVE  = 5'b00010,
    ST_SINE  = 5'b00100,
    ST_BASIS = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t     state;
  logic [4:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SINE;
      step  <= 5'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          step <= 5'd0;
          if (start) state <= go_move ? ST_MOVE : ST_SINE;
        end
        ST_MOVE: begin
          step <= (step == 5'd3) ? 5'd0 : step + 5'd1;
          if (step == 5'd3) state <= ST_SINE;
        end
        ST_SINE: begin
          step <= (step == 5'd8) ? 5'd0 : step + 5'd1;
          if (step == 5'd8) state <= ST_BASIS;
        end
        ST_BASIS: begin
          step <= (step == 5'd16) ? 5'd0 : step + 5'd1;
          if (step == 5'd16) state <= ST_DONE;
        end
        ST_DONE: begin
          step  <= 5'd0;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign stat.idle = (state == ST_IDLE);
  assign stat.done = (state == ST_DONE);

  always_comb begin
    ctrl = '{a_sel: A_SY, b_sel: B_CP, mode: M_HOLD, wb: W_NONE,
             sin_ang: ANG_SIN_YAW, sin_cap: 1'b0, cap_sel: ANG_SIN_YAW};
    unique case (state)
      ST_MOVE: begin
        ctrl.a_sel = A_K;
        unique case (step)
          5'd0: begin ctrl.b_sel = B_V0; ctrl.mode = M_LOAD; end
          5'd1: begin ctrl.b_sel = B_V1; ctrl.mode = M_LOAD; ctrl.wb = W_P0; end
          5'd2: begin ctrl.b_sel = B_V2; ctrl.mode = M_LOAD; ctrl.wb = W_P1; end
          default: ctrl.wb = W_P2;
        endcase
      end
      ST_SINE: begin
        unique case (step)
          5'd0: ctrl.sin_ang = ANG_SIN_YAW;
          5'd1: ctrl.sin_ang = ANG_COS_YAW;
          5'd2: ctrl.sin_ang = ANG_SIN_PITCH;
          5'd3: ctrl.sin_ang = ANG_COS_PITCH;
          5'd4: ctrl.sin_ang = ANG_SIN_ROLL;
          5'd5: ctrl.sin_ang = ANG_COS_ROLL;
          default: ctrl.sin_ang = ANG_SIN_YAW;
        endcase
        // rom pipeline is three deep
        ctrl.sin_cap = (step >= 5'd3);
        unique case (step)
          5'd4:    ctrl.cap_sel = ANG_COS_YAW;
          5'd5:    ctrl.cap_sel = ANG_SIN_PITCH;
          5'd6:    ctrl.cap_sel = ANG_COS_PITCH;
          5'd7:    ctrl.cap_sel = ANG_SIN_ROLL;
          5'd8:    ctrl.cap_sel = ANG_COS_ROLL;
          default: ctrl.cap_sel = ANG_SIN_YAW;
        endcase
      end
      ST_BASIS: begin
        unique case (step)
          5'd0: begin
            ctrl.a_sel = A_SY; ctrl.b_sel = B_CP; ctrl.mode = M_LOAD; ctrl.wb = W_FY;
          end
          5'd1: begin
            ctrl.a_sel = A_CP; ctrl.b_sel = B_CY; ctrl.mode = M_NLOAD; ctrl.wb = W_FX;
          end
          5'd2: begin
            ctrl.a_sel = A_CP; ctrl.b_sel = B_CR; ctrl.mode = M_LOAD; ctrl.wb = W_FZ;
          end
          5'd3: begin
            ctrl.a_sel = A_SY; ctrl.b_sel = B_SP; ctrl.mode = M_LOAD; ctrl.wb = W_UY;
          end
          5'd4: begin
            ctrl.a_sel = A_CY; ctrl.b_sel = B_SR; ctrl.mode = M_LOAD; ctrl.wb = W_T;
          end
          5'd5: begin
            ctrl.a_sel = A_T; ctrl.b_sel = B_CR; ctrl.mode = M_NSH_SUB;
          end
          5'd6: begin
            ctrl.a_sel = A_SP; ctrl.b_sel = B_CR; ctrl.mode = M_LOAD; ctrl.wb = W_UX;
          end
          5'd7: begin
            ctrl.a_sel = A_SY; ctrl.b_sel = B_SR; ctrl.mode = M_LOAD; ctrl.wb = W_T;
          end
          5'd8: begin
            ctrl.a_sel = A_T; ctrl.b_sel = B_CY; ctrl.mode = M_NSH_ADD;
          end
          5'd9: ctrl.wb = W_UZ;
          5'd10: begin
            ctrl.a_sel = A_FY; ctrl.b_sel = B_UZ; ctrl.mode = M_LOAD;
          end
          5'd11: begin
            ctrl.a_sel = A_FZ; ctrl.b_sel = B_UY; ctrl.mode = M_SUB;
          end
          5'd12: begin
            ctrl.a_sel = A_FZ; ctrl.b_sel = B_UX; ctrl.mode = M_LOAD; ctrl.wb = W_RX;
          end
          5'd13: begin
            ctrl.a_sel = A_FX; ctrl.b_sel = B_UZ; ctrl.mode = M_SUB;
          end
          5'd14: begin
            ctrl.a_sel = A_FX; ctrl.b_sel = B_UY; ctrl.mode = M_LOAD; ctrl.wb = W_RY;
          end
          5'd15: begin
            ctrl.a_sel = A_FY; ctrl.b_sel = B_UX; ctrl.mode = M_SUB;
          end
          default: ctrl.wb = W_RZ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

>>> sv/euler_camera_basis_and_motion_core.sv
// Camera basis and motion core. Each command transfer on s_* moves the eye, turns
// yaw/pitch or does neither, then rebuilds the forward, up and right vectors and
// returns one result on m_*. One shared 32x16 multiplier walks the 3 move products
// and the 15 basis and cross products one per cycle, and the six sines go one per
// cycle through a three-stage table pipeline. The block takes the next command
// once the result has been taken. After reset and after each write to a known
// register index it rebuilds the basis the same way, during which it takes no
// command. Registers are written on cfg_* only while no command is outstanding.
// depends on cebm_pkg, cebm_sine, cebm_mac, cebm_seq
`timescale 1ns / 1ps

module euler_camera_basis_and_motion_core import cebm_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // operation[3:0], frame_time[19:4], zero fill
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [239:0] m_tdata,   // pos_x, pos_y, pos_z, fwd_x..z, upv_x..z, rgt_x..z
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  typedef enum logic [1:0] {V_FWD, V_UP, V_RGT} vsel_t;

  ctrl_t ctrl;
  stat_t stat;

  logic        in_acc, cfg_acc, cfg_known, start, go_move, emit;
  logic [3:0]  op;
  logic [15:0] ft;
  logic [10:0] turn_d;
  logic [20:0] turn_raw;

  logic [15:0]        yaw;
  logic signed [13:0] pitch;
  logic signed [14:0] roll;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [15:0] fx, fy, fz, ux, uy, uz, rx, ry, rz;
  logic signed [15:0] sy, cy, sp, cp, sr, cr;
  logic signed [31:0] tmp;
  logic [18:0]        kft;
  vsel_t              vsel;
  logic               neg;

  logic signed [16:0] ang;
  logic signed [15:0] sine;
  logic signed [31:0] a;
  logic signed [15:0] b;
  logic signed [47:0] acc, r14, r28;
  logic signed [15:0] v0, v1, v2;

  logic signed [16:0] yaw_left;
  logic [16:0]        yaw_right;
  logic signed [14:0] pitch_up, pitch_down;

  assign op     = s_tdata[3:0];
  assign ft     = s_tdata[19:4];
  assign in_acc  = s_tvalid & s_tready;
  assign cfg_acc = cfg_valid & cfg_ready;
  assign cfg_known = (cfg_index <= CFG_POS_Z);
  assign start   = in_acc | (cfg_acc & cfg_known);
  assign go_move = in_acc & (op >= OP_FWD) & (op <= OP_STRAFE_L);

  assign s_tready  = stat.idle & ~m_tvalid & ~cfg_valid;
  assign cfg_ready = stat.idle & ~m_tvalid;

  assign turn_raw = 21'(ft) * 21'd25 + 21'd512;
  assign turn_d   = turn_raw[20:10];

  assign yaw_left   = $signed({1'b0, yaw}) - $signed({6'd0, turn_d});
  assign yaw_right  = {1'b0, yaw} + {6'd0, turn_d};
  assign pitch_up   = 15'(pitch) - $signed({4'd0, turn_d});
  assign pitch_down = 15'(pitch) + $signed({4'd0, turn_d});

  cebm_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .go_move (go_move),
    .ctrl    (ctrl),
    .stat    (stat)
  );

  always_comb begin
    case (ctrl.sin_ang)
      ANG_COS_YAW:   ang = $signed({1'b0, yaw}) + 17'sd5760;
      ANG_SIN_PITCH: ang = 17'(pitch);
      ANG_COS_PITCH: ang = 17'(pitch) + 17'sd5760;
      ANG_SIN_ROLL:  ang = 17'(roll);
      ANG_COS_ROLL:  ang = 17'(roll) + 17'sd5760;
      default:       ang = $signed({1'b0, yaw});
    endcase
  end

  cebm_sine #(.DEPTH(SINE_TABLE_DEPTH)) u_sine (
    .clk   (clk),
    .angle (ang),
    .sine  (sine)
  );

  always_comb begin
    case (vsel)
      V_UP:    begin v0 = ux; v1 = uy; v2 = uz; end
      V_RGT:   begin v0 = rx; v1 = ry; v2 = rz; end
      default: begin v0 = fx; v1 = fy; v2 = fz; end
    endcase
    case (ctrl.a_sel)
      A_CY:    a = 32'(cy);
      A_SP:    a = 32'(sp);
      A_CP:    a = 32'(cp);
      A_T:     a = tmp;
      A_FX:    a = 32'(fx);
      A_FY:    a = 32'(fy);
      A_FZ:    a = 32'(fz);
      A_K:     a = $signed({13'd0, kft});
      default: a = 32'(sy);
    endcase
    case (ctrl.b_sel)
      B_CY:    b = cy;
      B_CR:    b = cr;
      B_SP:    b = sp;
      B_SR:    b = sr;
      B_UX:    b = ux;
      B_UY:    b = uy;
      B_UZ:    b = uz;
      B_V0:    b = v0;
      B_V1:    b = v1;
      B_V2:    b = v2;
      default: b = cp;
    endcase
  end

  cebm_mac u_mac (
    .clk  (clk),
    .a    (a),
    .b    (b),
    .mode (ctrl.mode),
    .acc  (acc)
  );

  // round half up back to q1.14
  assign r14 = (acc + 48'sd8192) >>> 14;
  assign r28 = (acc + 48'sd134217728) >>> 28;

  function automatic logic signed [31:0] step_pos(input logic signed [31:0] p,
                                                  input logic signed [47:0] d,
                                                  input logic               sub);
    logic signed [49:0] s;
    s = sub ? 50'(p) - 50'(d) : 50'(p) + 50'(d);
    return sat32(s);
  endfunction

  // live camera state: angles and eye position
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw   <= RST_YAW;
      pitch <= RST_PITCH;
      roll  <= '0;
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else begin
      if (cfg_acc) begin
        case (cfg_index)
          CFG_ROLL:  roll  <= cfg_data[14:0];
          CFG_PITCH: pitch <= cfg_data[13:0];
          CFG_YAW:   yaw   <= {1'b0, cfg_data[14:0]};
          CFG_POS_X: pos_x <= cfg_data;
          CFG_POS_Y: pos_y <= cfg_data;
          CFG_POS_Z: pos_z <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        case (op)
          OP_TURN_LEFT:  yaw <= (yaw_left < 17'sd0) ? 16'd23040 : yaw_left[15:0];
          OP_TURN_RIGHT: yaw <= (yaw_right > 17'd23040) ? 16'd0 : yaw_right[15:0];
          OP_TURN_UP:    pitch <= (pitch_up < -15'sd5760) ? -14'sd5760 : pitch_up[13:0];
          OP_TURN_DOWN:  pitch <= (pitch_down > 15'sd5760) ? 14'sd5760 : pitch_down[13:0];
          default: ;
        endcase
      end
      case (ctrl.wb)
        W_P0: pos_x <= step_pos(pos_x, r14, neg);
        W_P1: pos_y <= step_pos(pos_y, r14, neg);
        W_P2: pos_z <= step_pos(pos_z, r14, neg);
        default: ;
      endcase
    end
  end

  // basis, sines and move operands
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kft <= 19'(ft) * 19'd5;
      neg <= (op == OP_BACK) || (op == OP_DOWN) || (op == OP_STRAFE_L);
      case (op) inside
        OP_UP, OP_DOWN:           vsel <= V_UP;
        OP_STRAFE_R, OP_STRAFE_L: vsel <= V_RGT;
        default:                  vsel <= V_FWD;
      endcase
    end
    if (ctrl.sin_cap) begin
      case (ctrl.cap_sel)
        ANG_COS_YAW:   cy <= sine;
        ANG_SIN_PITCH: sp <= sine;
        ANG_COS_PITCH: cp <= sine;
        ANG_SIN_ROLL:  sr <= sine;
        ANG_COS_ROLL:  cr <= sine;
        default:       sy <= sine;
      endcase
    end
    case (ctrl.wb)
      W_FX: fx  <= clamp_unit(r14);
      W_FY: fy  <= sp;
      W_FZ: fz  <= clamp_unit(r14);
      W_UX: ux  <= clamp_unit(r28);
      W_UY: uy  <= clamp_unit(r14);
      W_UZ: uz  <= clamp_unit(r28);
      W_T:  tmp <= acc[31:0];
      W_RX: rx  <= clamp_unit(r14);
      W_RY: ry  <= clamp_unit(r14);
      W_RZ: rz  <= clamp_unit(r14);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (in_acc) begin
        emit <= 1'b1;
      end else if (cfg_acc) begin
        emit <= 1'b0;
      end
      if (stat.done && emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {rz, ry, rx, uz, uy, ux, fz, fy, fx, pos_z, pos_y, pos_x};

endmodule

>>> sv/cebm_checker.sv
// port-level checks of the camera core, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cebm_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic cfg_ready
);

  `ASSERT_NEXT(a_out_held, m_tvalid && !m_tready, m_tvalid)
  `ASSERT_SAME(a_no_take_while_pending, m_tvalid, !s_tready)
  `ASSERT_NEXT(a_busy_after_cmd, s_tvalid && s_tready, !s_tready && !m_tvalid)
  `ASSERT_NEXT(a_one_result, m_tvalid && m_tready, !m_tvalid)
  `ASSERT_SAME(a_no_cfg_while_pending, m_tvalid, !cfg_ready)

endmodule

bind euler_camera_basis_and_motion_core cebm_checker u_cebm_checker (.*);

>>> tb/tb.sv
// self-checking testbench for euler_camera_basis_and_motion_core
// carries its own fixed-point camera predictor; depends on cebm_pkg and the core
`timescale 1ns / 1ps

module tb;
  import cebm_pkg::*;

  localparam int          TABLE_DEPTH = 1024;
  localparam int          QSTEPS      = TABLE_DEPTH / 4;
  localparam int          SETTLE      = 40;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam logic [3:0]  OP_LAST_CODE = 4'd15;
  localparam logic [2:0]  CFG_UNUSED   = 3'd6;
  localparam longint unsigned ONE_Q30  = 64'd1073741824;
  localparam longint unsigned HALF_PI  = 64'd1686629713;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [23:0]  s_tdata = '0;   // operation[3:0], frame_time[19:4], zero fill
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [239:0] m_tdata;        // pos_x, pos_y, pos_z, fwd_x..z, upv_x..z, rgt_x..z
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  euler_camera_basis_and_motion_core #(.SINE_TABLE_DEPTH(TABLE_DEPTH)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct {
    logic [31:0] pos[3];
    logic [15:0] vec[9];   // fwd x..z, upv x..z, rgt x..z
  } cam_view_t;

  typedef struct {
    logic [3:0]  op;
    logic [15:0] ft;
    bit          typed;
    logic [31:0] pos[3];
  } command_t;

  // camera state as the predictor sees it
  int     roll, pitch, yaw;
  longint eye[3];
  longint fwd[3], upv[3], rgt[3];

  cam_view_t view_q[$];
  command_t  cmd_q[$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        mismatches = 0;
  int        n_results = 0;
  int        n_cfg = 0;
  int        cycles = 0;
  int        op_seen[16];

  function automatic longint round_q(longint p, int s);
    return (p + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_q14(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic longint quarter_sine(longint r);
    longint unsigned x, u, u2, h, s;
    x  = (longint'(r) * QSTEPS + 2880) / 5760;
    u  = x * HALF_PI / QSTEPS;
    u2 = (u * u) >> 30;
    h  = ONE_Q30 - u2 / 72;
    h  = ONE_Q30 - ((u2 * h) >> 30) / 42;
    h  = ONE_Q30 - ((u2 * h) >> 30) / 20;
    h  = ONE_Q30 - ((u2 * h) >> 30) / 6;
    s  = (u * h) >> 30;
    s  = (s + 32768) >> 16;
    if (s > 16384) s = 16384;
    return longint'(s);
  endfunction

  function automatic longint sine_deg64(longint a);
    longint m, k, r;
    m = a % FULL_TURN;
    if (m < 0) m += FULL_TURN;
    k = m / QUARTER_TURN;
    r = m % QUARTER_TURN;
    case (k)
      0: return quarter_sine(r);
      1: return quarter_sine(QUARTER_TURN - r);
      2: return -quarter_sine(r);
      default: return -quarter_sine(QUARTER_TURN - r);
    endcase
  endfunction

  function automatic void rebuild_basis();
    longint sy, cy, sp, cp, sr, cr;
    sy = sine_deg64(yaw);   cy = sine_deg64(yaw + QUARTER_TURN);
    sp = sine_deg64(pitch); cp = sine_deg64(pitch + QUARTER_TURN);
    sr = sine_deg64(roll);  cr = sine_deg64(roll + QUARTER_TURN);
    fwd[0] = clamp_q14(round_q(sy * cp, 14));
    fwd[1] = clamp_q14(sp);
    fwd[2] = clamp_q14(round_q(-(cp * cy), 14));
    upv[0] = clamp_q14(round_q(-(cy * sr) * 16384 - sy * sp * cr, 28));
    upv[1] = clamp_q14(round_q(cp * cr, 14));
    upv[2] = clamp_q14(round_q(-(sy * sr) * 16384 + sp * cr * cy, 28));
    rgt[0] = clamp_q14(round_q(fwd[1] * upv[2] - fwd[2] * upv[1], 14));
    rgt[1] = clamp_q14(round_q(fwd[2] * upv[0] - fwd[0] * upv[2], 14));
    rgt[2] = clamp_q14(round_q(fwd[0] * upv[1] - fwd[1] * upv[0], 14));
  endfunction

  function automatic void step_eye(longint v[3], longint ft, bit back);
    longint d, s;
    for (int i = 0; i < 3; i++) begin
      d = round_q(5 * ft * v[i], 14);
      s = back ? eye[i] - d : eye[i] + d;
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      eye[i] = s;
    end
  endfunction

  function automatic void apply_register(logic [2:0] idx, logic [31:0] val);
    case (idx)
      CFG_ROLL:  roll = int'($signed(val[14:0]));
      CFG_PITCH: pitch = int'($signed(val[13:0]));
      CFG_YAW:   yaw = int'(val[14:0]);
      CFG_POS_X: eye[0] = longint'($signed(val));
      CFG_POS_Y: eye[1] = longint'($signed(val));
      CFG_POS_Z: eye[2] = longint'($signed(val));
      default:   return;
    endcase
    rebuild_basis();
  endfunction

  function automatic cam_view_t camera_after(logic [3:0] op, logic [15:0] ft);
    cam_view_t r;
    int d;
    d = int'((25 * longint'(ft) + 512) >> 10);
    case (op)
      OP_FWD:        step_eye(fwd, ft, 1'b0);
      OP_BACK:       step_eye(fwd, ft, 1'b1);
      OP_UP:         step_eye(upv, ft, 1'b0);
      OP_DOWN:       step_eye(upv, ft, 1'b1);
      OP_STRAFE_R:   step_eye(rgt, ft, 1'b0);
      OP_STRAFE_L:   step_eye(rgt, ft, 1'b1);
      OP_TURN_LEFT:  begin
        yaw -= d;
        if (yaw < 0) yaw = FULL_TURN;
      end
      OP_TURN_RIGHT: begin
        yaw += d;
        if (yaw > FULL_TURN) yaw = 0;
      end
      OP_TURN_UP:    begin
        pitch -= d;
        if (pitch < -QUARTER_TURN) pitch = -QUARTER_TURN;
      end
      OP_TURN_DOWN:  begin
        pitch += d;
        if (pitch > QUARTER_TURN) pitch = QUARTER_TURN;
      end
      default: ;
    endcase
    rebuild_basis();
    for (int i = 0; i < 3; i++) begin
      r.pos[i]     = eye[i][31:0];
      r.vec[i]     = fwd[i][15:0];
      r.vec[3 + i] = upv[i][15:0];
      r.vec[6 + i] = rgt[i][15:0];
    end
    return r;
  endfunction

  // track every transfer on the three channels, sampled at the edge
  always @(posedge clk) begin
    cam_view_t want;
    command_t  cmd;
    logic [31:0] got32;
    logic [15:0] got16;
    if (rst) begin
      roll = 0; pitch = int'(RST_PITCH); yaw = int'(RST_YAW);
      eye[0] = 0; eye[1] = 0; eye[2] = 0;
      rebuild_basis();
    end else begin
      if (cfg_valid && cfg_ready) begin
        apply_register(cfg_index, cfg_data);
        n_cfg++;
      end
      if (s_tvalid && s_tready) begin
        cmd  = cmd_q.pop_front();
        want = camera_after(s_tdata[3:0], s_tdata[19:4]);
        op_seen[s_tdata[3:0]]++;
        if (cmd.typed) want.pos = cmd.pos;
        view_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        n_results++;
        if (view_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result with nothing expected");
        end else begin
          want = view_q.pop_front();
          for (int i = 0; i < 3; i++) begin
            got32 = m_tdata[32 * i +: 32];
            if (got32 !== want.pos[i]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("pos[%0d] mismatch: expected %0d got %0d", i,
                         $signed(want.pos[i]), $signed(got32));
            end
          end
          for (int j = 0; j < 9; j++) begin
            got16 = m_tdata[96 + 16 * j +: 16];
            if (got16 !== want.vec[j]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("vector field %0d mismatch: expected %0d got %0d", j,
                         $signed(want.vec[j]), $signed(got16));
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", view_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_command(logic [3:0] op, logic [15:0] ft, bit typed,
                              logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    command_t c;
    c.op = op; c.ft = ft; c.typed = typed;
    c.pos[0] = px; c.pos[1] = py; c.pos[2] = pz;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    cmd_q.push_back(c);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, ft, op};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    // let the monitor log a transfer made at the edge just passed
    @(posedge clk);
    while (view_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_all(logic [31:0] r, logic [31:0] p, logic [31:0] y,
                           logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    wait_idle();
    write_reg(CFG_ROLL, r);
    write_reg(CFG_PITCH, p);
    write_reg(CFG_YAW, y);
    write_reg(CFG_POS_X, px);
    write_reg(CFG_POS_Y, py);
    write_reg(CFG_POS_Z, pz);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_frame_time();
    case ($urandom_range(4))
      0: return 16'($urandom_range(255));
      1: return 16'($urandom_range(4095));
      2: return 16'($urandom_range(65535, 65000));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_chunk(int n);
    logic [3:0] op;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) op = 4'($urandom_range(OP_LAST_CODE, OP_TURN_DOWN + 1));
      else op = 4'($urandom_range(OP_TURN_DOWN, OP_RECOMPUTE));
      send_command(op, pick_frame_time(), 1'b0, '0, '0, '0);
    end
  endtask

  task automatic random_setting();
    logic [31:0] p[3];
    for (int i = 0; i < 3; i++)
      case ($urandom_range(3))
        0: p[i] = 32'h7fff_fff0 + $urandom_range(15);
        1: p[i] = 32'h8000_0000 + $urandom_range(15);
        default: p[i] = $urandom;
      endcase
    write_all($urandom_range(1) ? 32'($signed(15'($urandom))) : 32'($urandom_range(11520)),
              $urandom_range(1) ? 32'($signed(14'($urandom))) : 32'($urandom_range(5760)),
              32'($urandom_range(32767)), p[0], p[1], p[2]);
  endtask

  command_t directed[20];
  int       idle_mix[3][2] = '{'{29, 80}, '{80, 29}, '{0, 0}};

  initial begin
    // reset values of position are known: recompute and a zero-time move leave them at 0
    directed[0]  = '{OP_RECOMPUTE, 16'd0, 1'b1, '{32'd0, 32'd0, 32'd0}};
    directed[1]  = '{OP_FWD, 16'd0, 1'b1, '{32'd0, 32'd0, 32'd0}};
    directed[2]  = '{OP_FWD, 16'hFFFF, 1'b0, '{0, 0, 0}};
    directed[3]  = '{OP_BACK, 16'hFFFF, 1'b0, '{0, 0, 0}};
    directed[4]  = '{OP_UP, 16'hFFFF, 1'b0, '{0, 0, 0}};
    directed[5]  = '{OP_DOWN, 16'hFFFF, 1'b0, '{0, 0, 0}};
    directed[6]  = '{OP_STRAFE_R, 16'hFFFF, 1'b0, '{0, 0, 0}};
    directed[7]  = '{OP_STRAFE_L, 16'hFFFF, 1'b0, '{0, 0, 0}};
    directed[8]  = '{OP_TURN_DOWN + 4'd1, 16'h5555, 1'b0, '{0, 0, 0}};
    directed[9]  = '{OP_LAST_CODE, 16'hAAAA, 1'b0, '{0, 0, 0}};
    // yaw past a full turn wraps to zero, then below zero wraps to a full turn
    for (int i = 10; i < 14; i++) directed[i] = '{OP_TURN_RIGHT, 16'hFFFF, 1'b0, '{0, 0, 0}};
    directed[14] = '{OP_TURN_LEFT, 16'hFFFF, 1'b0, '{0, 0, 0}};
    // pitch clamps at straight up
    directed[15] = '{OP_TURN_UP, 16'hFFFF, 1'b0, '{0, 0, 0}};
    directed[16] = '{OP_TURN_UP, 16'hFFFF, 1'b0, '{0, 0, 0}};
    directed[17] = '{OP_TURN_DOWN, 16'hFFFF, 1'b0, '{0, 0, 0}};
    directed[18] = '{OP_TURN_DOWN, 16'd1, 1'b0, '{0, 0, 0}};
    directed[19] = '{OP_TURN_LEFT, 16'd20, 1'b0, '{0, 0, 0}};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_command(directed[i].op, directed[i].ft, directed[i].typed,
                   directed[i].pos[0], directed[i].pos[1], directed[i].pos[2]);

    // extremes of every register, saturating positions, pitch clamp from above
    write_all(32'd11520, 32'd5760, 32'd23040, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    for (int op = OP_FWD; op <= OP_TURN_DOWN; op++)
      send_command(4'(op), 16'hFFFF, 1'b0, '0, '0, '0);
    write_all(-32'sd11520, -32'sd5760, 32'd0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    // an index beyond the register list changes nothing
    wait_idle();
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    @(posedge clk);
    for (int op = OP_FWD; op <= OP_TURN_DOWN; op++)
      send_command(4'(op), 16'hFFFF, 1'b0, '0, '0, '0);

    for (int m = 0; m < 3; m++) begin
      send_idle_pct = idle_mix[m][0];
      recv_idle_pct = idle_mix[m][1];
      for (int c = 0; c < 4; c++) begin
        random_setting();
        random_chunk(100);
      end
    end

    wait_idle();
    $display("%0d results checked, %0d register writes, all 16 operation codes driven",
             n_results, n_cfg);
    $display("mismatches: %0d, turn ops right/left/up/down: %0d/%0d/%0d/%0d", mismatches,
             op_seen[OP_TURN_RIGHT], op_seen[OP_TURN_LEFT], op_seen[OP_TURN_UP],
             op_seen[OP_TURN_DOWN]);
    if (mismatches == 0 && view_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/cebm_pkg.sv
sv/cebm_sine.sv
sv/cebm_mac.sv
sv/cebm_seq.sv
sv/euler_camera_basis_and_motion_core.sv
sv/cebm_checker.sv
tb/tb.sv
